// ----- rtl/wdf_pkg.sv -----
package wdf_pkg;
	localparam int unsigned MaxDimDef = 256;
	localparam int unsigned MaxRadiusDef = 31;
	localparam logic [4:0] RadiusRst = 5'd15;
	localparam logic [7:0] ThreshRst = 8'd220;
	localparam logic [8:0] DimRst = 9'd256;
	localparam logic [16:0] FullScaleSq = 17'd65025;
	localparam logic [7:0] LevelMax = 8'd255;

	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_THRESH = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture query, start scan
		logic scan;      // issue next mask read
		logic centre;    // latch centre class from read data
		logic cmp;       // compare one window read
		logic sqrt_go;   // start root
		logic sqrt_step;
		logic div_go;
		logic div_step;
		logic finish;    // form level into output reg
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
		logic sqrt_done;
		logic div_done;
	} dp_sts_t;
endpackage

// ----- rtl/windowed_distance_field_pixel_core.sv -----
// Windowed distance field per pixel. Load beats (req_type 0) store one mask
// bit. A query beat (req_type 1) scans the 2R x 2R window around the pixel,
// one mask read per cycle from the mask memory, then runs a bit-per-cycle
// square root (15 steps) and divide by R (16 steps); a query holds off new
// input until its result is formed, longer if the result is stalled.
// The mask memory has no reset; every pixel a query touches must have been
// loaded first. Configuration goes over the APB port: radius at 0x0,
// threshold 0x4, width 0x8, height 0xC.
module windowed_distance_field_pixel_core #(
	parameter int unsigned MAX_DIM    = wdf_pkg::MaxDimDef,
	parameter int unsigned MAX_RADIUS = wdf_pkg::MaxRadiusDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  field_value,
	output logic        pixel_inside,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [4:0] radius_q;
	logic [7:0] thresh_q;
	logic [8:0] width_q, height_q;
	wdf_pkg::dp_cmd_t cmd;
	wdf_pkg::dp_sts_t sts;
	wdf_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = wdf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= wdf_pkg::RadiusRst;
			thresh_q <= wdf_pkg::ThreshRst;
			width_q  <= wdf_pkg::DimRst;
			height_q <= wdf_pkg::DimRst;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				wdf_pkg::REG_RADIUS: radius_q <= pwdata[4:0];
				wdf_pkg::REG_THRESH: thresh_q <= pwdata[7:0];
				wdf_pkg::REG_WIDTH:  width_q  <= pwdata[8:0];
				wdf_pkg::REG_HEIGHT: height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			wdf_pkg::REG_RADIUS: prdata = {27'd0, radius_q};
			wdf_pkg::REG_THRESH: prdata = {24'd0, thresh_q};
			wdf_pkg::REG_WIDTH:  prdata = {23'd0, width_q};
			wdf_pkg::REG_HEIGHT: prdata = {23'd0, height_q};
			default: prdata = '0;
		endcase
	end

	wdf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_query(req_type), .in_rdy(in_ready),
		.out_valid(out_valid), .out_rdy(out_ready),
		.sts(sts), .cmd(cmd)
	);

	wdf_datapath #(.MAX_DIM(MAX_DIM), .MAX_RADIUS(MAX_RADIUS)) u_dp (
		.clk(clk),
		.in_store(in_valid && in_ready && !req_type),
		.pos_x(pos_x), .pos_y(pos_y), .red(red), .green(green), .blue(blue),
		.radius_cfg(radius_q), .thresh_cfg(thresh_q),
		.width_cfg(width_q), .height_cfg(height_q),
		.cmd(cmd), .sts(sts),
		.field_value(field_value), .pixel_inside(pixel_inside)
	);
endmodule

// ----- rtl/wdf_ctrl.sv -----
module wdf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_query,
	output logic              in_rdy,
	output logic              out_valid,
	input  logic              out_rdy,
	input  wdf_pkg::dp_sts_t  sts,
	output wdf_pkg::dp_cmd_t  cmd
);
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CRD    = 8'b0000_0010,
		S_CLAT   = 8'b0000_0100,
		S_SCAN   = 8'b0000_1000,
		S_DRAIN  = 8'b0001_0000,
		S_SQRT   = 8'b0010_0000,
		S_DIV    = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   ovalid_q;
	logic   take;

	// out register may still hold a result while we take the next item
	assign in_rdy    = (state_q == S_IDLE);
	assign take      = in_valid && in_rdy;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && in_query) begin
					cmd.load = 1'b1;
					state_d  = S_CRD;
				end
			end
			S_CRD: state_d = S_CLAT;
			S_CLAT: begin
				cmd.centre = 1'b1;
				cmd.scan   = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				cmd.cmp  = 1'b1;
				if (sts.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.cmp     = 1'b1;
				cmd.sqrt_go = 1'b1;
				state_d     = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) begin
					cmd.div_go = 1'b1;
					state_d    = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!ovalid_q || out_rdy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) ovalid_q <= 1'b1;
			else if (out_rdy) ovalid_q <= 1'b0;
		end
	end
endmodule

// ----- rtl/wdf_datapath.sv -----
module wdf_datapath #(
	parameter int unsigned MAX_DIM    = wdf_pkg::MaxDimDef,
	parameter int unsigned MAX_RADIUS = wdf_pkg::MaxRadiusDef
) (
	input  logic              clk,
	input  logic              in_store,     // load beat accepted
	input  logic [7:0]        pos_x,
	input  logic [7:0]        pos_y,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [4:0]        radius_cfg,
	input  logic [7:0]        thresh_cfg,
	input  logic [8:0]        width_cfg,
	input  logic [8:0]        height_cfg,
	input  wdf_pkg::dp_cmd_t  cmd,
	output wdf_pkg::dp_sts_t  sts,
	output logic [7:0]        field_value,
	output logic              pixel_inside
);
	localparam int AW  = $clog2(MAX_DIM);
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int CW  = AW + 2;                 // signed coordinate width
	localparam int DW  = RW + 2;                 // signed offset width
	localparam int D2W = 2 * RW + 3;             // holds 4R^2 and 2*(2R)^2
	localparam int PW  = 2 * (CW + 1);           // full square of a distance
	localparam int VW  = D2W + 17;
	localparam int SW  = (VW + 1) / 2 + 1;
	localparam int SQN = (VW + 1) / 2;
	localparam int SQC = $clog2(SQN + 1);
	localparam int DVC = $clog2(SW + 1);
	localparam int DIMW = AW + 1;
	localparam logic [VW-1:0] FullScaleSqW = VW'(wdf_pkg::FullScaleSq);

	logic mem [2**(2*AW)];
	logic rd_bit_q;
	logic [2*AW-1:0] waddr, raddr;

	// effective config
	logic [RW-1:0]   rad;
	logic [DIMW-1:0] w_eff, h_eff;
	always_comb begin
		if (radius_cfg == '0) rad = RW'(1);
		else if (32'(radius_cfg) > MAX_RADIUS) rad = RW'(MAX_RADIUS);
		else rad = RW'(radius_cfg);
		if (width_cfg == '0) w_eff = DIMW'(1);
		else if (32'(width_cfg) > MAX_DIM) w_eff = DIMW'(MAX_DIM);
		else w_eff = DIMW'(width_cfg);
		if (height_cfg == '0) h_eff = DIMW'(1);
		else if (32'(height_cfg) > MAX_DIM) h_eff = DIMW'(MAX_DIM);
		else h_eff = DIMW'(height_cfg);
	end

	// load path
	logic ld_ok, ld_bit;
	assign ld_ok = (32'(pos_x) < MAX_DIM) && (32'(pos_y) < MAX_DIM);
	assign ld_bit = (red > thresh_cfg) && (green > thresh_cfg) && (blue > thresh_cfg);
	assign waddr = {AW'(pos_y), AW'(pos_x)};

	// query registers
	logic [CW-1:0] px_q, py_q;
	logic [RW-1:0] rad_q;
	logic [DIMW-1:0] w_q, h_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic centre_q;
	logic [D2W-1:0] best_q, d2_s1;
	logic cmp_vld_s1;
	logic [7:0] fv_q;

	// window position for the current offset, clamped
	logic signed [CW:0] lx, ly;
	logic [AW-1:0] rx, ry;
	always_comb begin
		lx = $signed({1'b0, px_q}) + (CW+1)'(dx_q);
		ly = $signed({1'b0, py_q}) + (CW+1)'(dy_q);
		if (lx >= $signed((CW+1)'(w_q))) lx = $signed((CW+1)'(w_q)) - 2'sd1;
		if (lx < 0) lx = '0;
		if (ly >= $signed((CW+1)'(h_q))) ly = $signed((CW+1)'(h_q)) - 2'sd1;
		if (ly < 0) ly = '0;
		rx = lx[AW-1:0];
		ry = ly[AW-1:0];
	end

	logic signed [DW-1:0] last_off;
	logic scan_last, sqrt_done, div_done;
	assign last_off = $signed(DW'(rad_q)) - 2'sd1;
	assign scan_last = (dx_q == last_off) && (dy_q == last_off);

	// centre read uses saturated query position (positions are < MAX_DIM here
	// when pos width fits; saturate otherwise)
	logic [AW-1:0] cx, cy;
	assign cx = (32'(pos_x) > MAX_DIM - 1) ? AW'(MAX_DIM - 1) : AW'(pos_x);
	assign cy = (32'(pos_y) > MAX_DIM - 1) ? AW'(MAX_DIM - 1) : AW'(pos_y);
	logic [2*AW-1:0] caddr_q;
	logic scanning_q;

	assign raddr = scanning_q ? {ry, rx} : caddr_q;

	always_ff @(posedge clk) begin
		if (in_store && ld_ok) mem[waddr] <= ld_bit;
		rd_bit_q <= mem[raddr];
	end

	// distance of the pixel read this cycle, registered with the read;
	// far pixels of an off-image query saturate above any 4R^2
	logic signed [CW:0] ex, ey;
	logic signed [PW-1:0] exx, eyy;
	logic [PW:0] d2_full;
	logic [D2W-1:0] d2_c;
	assign ex = lx - $signed({1'b0, px_q});
	assign ey = ly - $signed({1'b0, py_q});
	assign exx = ex * ex;
	assign eyy = ey * ey;
	assign d2_full = {1'b0, exx} + {1'b0, eyy};
	assign d2_c = (d2_full > (PW+1)'({D2W{1'b1}})) ? {D2W{1'b1}} : d2_full[D2W-1:0];

	// last compare lands with the root start
	logic cmp_hit;
	logic [D2W-1:0] best_nx;
	assign cmp_hit = cmd.cmp && cmp_vld_s1 && (rd_bit_q != centre_q) && (d2_s1 < best_q);
	assign best_nx = cmp_hit ? d2_s1 : best_q;

	// square root and divide
	logic [VW-1:0] v_q, rem_q;
	logic [SW-1:0] res_q;
	logic [SQC-1:0] sq_cnt_q;
	logic [SW+1:0] trial;
	logic [SW-1:0] s_q, quot_q, dividend;
	logic [RW:0] dr_q;
	logic [DVC-1:0] dv_cnt_q;
	logic [7:0] lvl;
	logic [VW+2:0] rem_sh;

	assign sqrt_done = (sq_cnt_q == '0);
	assign div_done  = (dv_cnt_q == '0);
	assign sts = '{scan_last: scan_last, sqrt_done: sqrt_done, div_done: div_done};
	assign rem_sh = {rem_q, v_q[VW-1 -: 2]};
	assign trial  = {res_q, 2'b01};

	always_ff @(posedge clk) begin
		cmp_vld_s1 <= cmd.scan;
		if (cmd.load) begin
			px_q <= CW'(pos_x);
			py_q <= CW'(pos_y);
			rad_q <= rad;
			w_q <= w_eff;
			h_q <= h_eff;
			dx_q <= -$signed(DW'(rad));
			dy_q <= -$signed(DW'(rad));
			caddr_q <= {cy, cx};
			scanning_q <= 1'b0;
			best_q <= D2W'(4 * rad * rad);
		end
		if (cmd.centre) centre_q <= rd_bit_q;
		if (cmd.scan) begin
			scanning_q <= 1'b1;
			d2_s1 <= d2_c;
			if (scanning_q) begin
				if (dy_q == last_off) begin
					dy_q <= -$signed(DW'(rad_q));
					dx_q <= dx_q + 2'sd1;
				end else begin
					dy_q <= dy_q + 2'sd1;
				end
			end
		end
		if (cmp_hit)
			best_q <= d2_s1;
		if (cmd.sqrt_go) begin
			v_q <= VW'(best_nx) * FullScaleSqW;
			rem_q <= '0;
			res_q <= '0;
			sq_cnt_q <= SQC'(SQN);
		end else if (cmd.sqrt_step && !sqrt_done) begin
			// one result bit per cycle
			if ({2'b00, rem_sh[VW:0]} >= (VW+3)'(trial)) begin
				rem_q <= VW'(rem_sh - (VW+3)'(trial));
				res_q <= {res_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= VW'(rem_sh);
				res_q <= {res_q[SW-2:0], 1'b0};
			end
			v_q <= {v_q[VW-3:0], 2'b00};
			sq_cnt_q <= sq_cnt_q - 1'b1;
		end
		if (cmd.div_go) begin
			// ceiling form for outside pixels: bump when root inexact
			s_q <= dividend;
			quot_q <= '0;
			dr_q <= '0;
			dv_cnt_q <= DVC'(SW);
		end else if (cmd.div_step && !div_done) begin
			if ({dr_q[RW-1:0], s_q[SW-1]} >= {1'b0, rad_q}) begin
				dr_q <= {dr_q[RW-1:0], s_q[SW-1]} - {1'b0, rad_q};
				quot_q <= {quot_q[SW-2:0], 1'b1};
			end else begin
				dr_q <= {dr_q[RW-1:0], s_q[SW-1]};
				quot_q <= {quot_q[SW-2:0], 1'b0};
			end
			s_q <= {s_q[SW-2:0], 1'b0};
			dv_cnt_q <= dv_cnt_q - 1'b1;
		end
		if (cmd.finish) begin
			fv_q <= lvl;
			pixel_inside <= centre_q;
		end
	end

	// dividend: floor root, or ceil root + R - 1 for outside pixels
	always_comb begin
		if (centre_q) dividend = res_q;
		else dividend = res_q + SW'(rem_q != '0) + SW'(rad_q) - SW'(1);
	end

	always_comb begin
		if (quot_q > SW'(wdf_pkg::LevelMax)) lvl = wdf_pkg::LevelMax;
		else lvl = quot_q[7:0];
		if (!centre_q) lvl = wdf_pkg::LevelMax - lvl;
	end

	assign field_value = fv_q;
endmodule

// ----- rtl/wdf_checker.sv -----
module wdf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       req_type,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] field_value,
	input logic       pixel_inside,
	input logic       pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_value)
			&& $stable(pixel_inside))
		else $error("result beat changed while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type |=> !in_ready)
		else $error("query accepted but input still ready");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !req_type && !out_valid |=> !out_valid)
		else $error("load produced a result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind windowed_distance_field_pixel_core wdf_checker u_wdf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.req_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
	.field_value(field_value), .pixel_inside(pixel_inside), .pready(pready)
);

// ----- tb/wdf_tb_pkg.sv -----
`timescale 1ns / 100ps
package wdf_tb_pkg;
	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	localparam int unsigned DimMax = 256;
	localparam int unsigned RadiusMax = 31;
endpackage

// ----- tb/wdf_checker.sv -----
`timescale 1ns / 100ps
module wdf_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  field_value,
	input  logic        pixel_inside,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic [7:0] level;
		logic       in_shape;
	} sdf_result_t;

	logic        mask_mem [0:wdf_tb_pkg::DimMax*wdf_tb_pkg::DimMax-1];
	logic [4:0]  radius_q;
	logic [7:0]  thresh_q;
	logic [8:0]  width_q;
	logic [8:0]  height_q;
	sdf_result_t expected_px [$];

	initial begin
		foreach (mask_mem[i]) mask_mem[i] = 1'b0;
		fail_count = 0;
		pending = 0;
		radius_q = wdf_pkg::RadiusRst;
		thresh_q = wdf_pkg::ThreshRst;
		width_q = wdf_pkg::DimRst;
		height_q = wdf_pkg::DimRst;
	end

	function automatic longint unsigned isqrt_floor(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic int eff_dim(logic [8:0] v);
		if (v == 0) return 1;
		if (v > wdf_tb_pkg::DimMax) return wdf_tb_pkg::DimMax;
		return int'(v);
	endfunction

	function automatic sdf_result_t distance_level(int px, int py);
		sdf_result_t res;
		int rad, w, h, lx, ly, ex, ey;
		logic centre;
		longint unsigned best, d2, v, s, c;
		rad = (radius_q == 0) ? 1 : int'(radius_q);
		if (rad > int'(wdf_tb_pkg::RadiusMax)) rad = int'(wdf_tb_pkg::RadiusMax);
		w = eff_dim(width_q);
		h = eff_dim(height_q);
		centre = mask_mem[py * wdf_tb_pkg::DimMax + px];
		best = 4 * rad * rad;
		for (int dx = -rad; dx < rad; dx++) begin
			lx = px + dx;
			if (lx >= w) lx = w - 1;
			if (lx < 0) lx = 0;
			for (int dy = -rad; dy < rad; dy++) begin
				ly = py + dy;
				if (ly >= h) ly = h - 1;
				if (ly < 0) ly = 0;
				if (mask_mem[ly * wdf_tb_pkg::DimMax + lx] != centre) begin
					ex = lx - px;
					ey = ly - py;
					d2 = ex * ex + ey * ey;
					if (d2 < best) best = d2;
				end
			end
		end
		v = 65025 * best;
		s = isqrt_floor(v);
		if (centre) begin
			c = s / rad;
			res.level = (c > 255) ? wdf_pkg::LevelMax : c[7:0];
		end else begin
			c = s;
			if (c * c < v) c++;
			c = (c + rad - 1) / rad;
			if (c > 255) c = 255;
			res.level = 8'(255 - c);
		end
		res.in_shape = centre;
		return res;
	endfunction

	always @(posedge clk) begin
		sdf_result_t exp_r;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (wdf_pkg::reg_idx_t'(paddr[3:2]))
					wdf_pkg::REG_RADIUS: radius_q <= pwdata[4:0];
					wdf_pkg::REG_THRESH: thresh_q <= pwdata[7:0];
					wdf_pkg::REG_WIDTH:  width_q <= pwdata[8:0];
					wdf_pkg::REG_HEIGHT: height_q <= pwdata[8:0];
				endcase
			end
			if (in_valid && in_ready) begin
				if (wdf_tb_pkg::req_kind_t'(req_type) == wdf_tb_pkg::REQ_LOAD)
					mask_mem[pos_y * wdf_tb_pkg::DimMax + pos_x] <=
						(red > thresh_q) && (green > thresh_q) && (blue > thresh_q);
				else
					expected_px = {expected_px, distance_level(pos_x, pos_y)};
			end
			if (out_valid && out_ready) begin
				if (expected_px.size() == 0) begin
					$display("%0t: result beat with none expected: level %0d inside %0d",
						$time, field_value, pixel_inside);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_px.pop_front();
					if (field_value !== exp_r.level || pixel_inside !== exp_r.in_shape) begin
						$display("%0t: mismatch exp level %0d inside %0d, got level %0d inside %0d",
							$time, exp_r.level, exp_r.in_shape, field_value, pixel_inside);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_px.size();
		end
	end
endmodule

// ----- tb/windowed_distance_field_pixel_core_tb.sv -----
`timescale 1ns / 100ps
module windowed_distance_field_pixel_core_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = wdf_tb_pkg::REQ_LOAD;
	logic [7:0]  pos_x = '0;
	logic [7:0]  pos_y = '0;
	logic [7:0]  red = '0;
	logic [7:0]  green = '0;
	logic [7:0]  blue = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  field_value;
	logic        pixel_inside;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;

	bit          loaded [0:wdf_tb_pkg::DimMax*wdf_tb_pkg::DimMax-1];
	bit          calm = 1'b0;
	int          cur_rad = 15;
	int          cur_thr = 220;
	int          cur_w = 256;
	int          cur_h = 256;
	int          inside_pct = 50;
	int          sent_cnt = 0;

	always #2 clk = ~clk;

	windowed_distance_field_pixel_core u_dut (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .pos_x, .pos_y,
		.red, .green, .blue, .out_valid, .out_ready, .field_value, .pixel_inside,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	wdf_scoreboard u_chk (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .pos_x, .pos_y,
		.red, .green, .blue, .out_valid, .out_ready, .field_value, .pixel_inside,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
	);

	always @(posedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);

	initial begin
		#100ms;
		$display("windowed_distance_field_pixel_core_tb: FAIL");
		$finish;
	end

	task automatic reg_write(wdf_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_beat(wdf_tb_pkg::req_kind_t kind, int x, int y, logic [7:0] r,
			logic [7:0] g, logic [7:0] b);
		if (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		pos_x <= x[7:0];
		pos_y <= y[7:0];
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_cnt++;
	endtask

	task automatic load_pixel(int x, int y);
		logic [7:0] ch [3];
		if (cur_thr < 255 && $urandom_range(99) < inside_pct) begin
			foreach (ch[i]) ch[i] = $urandom_range(255, cur_thr + 1);
		end else begin
			foreach (ch[i]) ch[i] = $urandom_range(255);
			if ($urandom_range(3) != 0) ch[$urandom_range(2)] = $urandom_range(cur_thr);
		end
		loaded[y * wdf_tb_pkg::DimMax + x] = 1'b1;
		send_beat(wdf_tb_pkg::REQ_LOAD, x, y, ch[0], ch[1], ch[2]);
	endtask

	// every mask bit the query will read must be loaded first
	task automatic query_pixel(int x, int y);
		int lx, ly;
		if (!loaded[y * wdf_tb_pkg::DimMax + x]) load_pixel(x, y);
		for (int dx = -cur_rad; dx < cur_rad; dx++) begin
			lx = x + dx;
			if (lx >= cur_w) lx = cur_w - 1;
			if (lx < 0) lx = 0;
			for (int dy = -cur_rad; dy < cur_rad; dy++) begin
				ly = y + dy;
				if (ly >= cur_h) ly = cur_h - 1;
				if (ly < 0) ly = 0;
				if (!loaded[ly * wdf_tb_pkg::DimMax + lx]) load_pixel(lx, ly);
			end
		end
		send_beat(wdf_tb_pkg::REQ_QUERY, x, y, $urandom_range(255), $urandom_range(255),
			$urandom_range(255));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(int rad, int thr, int w, int h);
		drain();
		reg_write(wdf_pkg::REG_RADIUS, rad);
		reg_write(wdf_pkg::REG_THRESH, thr);
		reg_write(wdf_pkg::REG_WIDTH, w);
		reg_write(wdf_pkg::REG_HEIGHT, h);
		cur_rad = (rad == 0) ? 1 : rad;
		cur_thr = thr;
		cur_w = (w == 0) ? 1 : (w > wdf_tb_pkg::DimMax ? wdf_tb_pkg::DimMax : w);
		cur_h = (h == 0) ? 1 : (h > wdf_tb_pkg::DimMax ? wdf_tb_pkg::DimMax : h);
	endtask

	// runs until about n_items beats have gone out
	task automatic random_phase(int n_items);
		int stop_at;
		int i;
		stop_at = sent_cnt + n_items;
		i = 0;
		while (sent_cnt < stop_at) begin
			if ($urandom_range(99) < 40)
				load_pixel($urandom_range(255), $urandom_range(255));
			else if ($urandom_range(99) < 80)
				query_pixel($urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
			else
				query_pixel($urandom_range(255), $urandom_range(255));
			if (i == 4 && $urandom_range(3) == 0) begin
				// hold off until all results are back
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			i++;
		end
	endtask

	initial begin
		int rad, w, h;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners of the full store, tiny radius
		set_config(1, 0, 256, 256);
		query_pixel(0, 0);
		query_pixel(255, 255);
		query_pixel(128, 127);
		load_pixel(255, 0);
		query_pixel(255, 0);
		// largest radius, small image, queries beyond the image edge
		set_config(31, 255, 6, 5);
		query_pixel(2, 2);
		query_pixel(200, 3);
		query_pixel(4, 250);
		set_config(0, 128, 0, 511);
		query_pixel(0, 100);
		query_pixel(0, 255);
		// all-inside image: no opposite class in the window; then a mostly outside reload
		inside_pct = 100;
		set_config(3, 10, 4, 4);
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++) load_pixel(x, y);
		query_pixel(1, 2);
		query_pixel(3, 3);
		inside_pct = 0;
		for (int y = 0; y < 4; y++)
			for (int x = 0; x < 4; x++) load_pixel(x, y);
		query_pixel(0, 1);

		for (int p = 0; p < 18; p++) begin
			inside_pct = $urandom_range(90, 10);
			rad = ($urandom_range(5) == 0) ? $urandom_range(31, 7) : $urandom_range(6, 1);
			w = $urandom_range(24, 1);
			h = $urandom_range(24, 1);
			case ($urandom_range(5))
				0: begin w = 256; rad = $urandom_range(2, 1); end
				1: begin h = 511; rad = $urandom_range(2, 1); end
				2: begin w = 0; end
				default: ;
			endcase
			if (rad > 12) begin
				w = $urandom_range(10, 1);
				h = $urandom_range(10, 1);
			end
			set_config(rad, $urandom_range(255), w, h);
			calm = (p == 9);
			random_phase(28);
		end
		calm = 1'b0;

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("windowed_distance_field_pixel_core_tb: PASS");
		else
			$display("windowed_distance_field_pixel_core_tb: FAIL");
		$finish;
	end
endmodule
